>>> hw/rtl/servo_angle_to_pulse_defines.svh
// assertion macros for the servo pulse block
// clk and arst_n must be visible where a macro is used
`ifndef SERVO_ANGLE_TO_PULSE_DEFINES_SVH
`define SERVO_ANGLE_TO_PULSE_DEFINES_SVH

// consequent checked on the same edge
`define SAP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked on the following edge
`define SAP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sap_pkg.sv
`default_nettype none

package sap_pkg;

	// register indexes on the configuration channel
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW_ANGLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DEADBAND = 3'd5;

	// command codes
	localparam logic CMD_ANGLE = 1'b0;
	localparam logic CMD_RAW   = 1'b1;

	// build-time limits on the pulse range
	localparam logic [15:0] PULSE_FLOOR   = 16'd500;
	localparam logic [15:0] PULSE_CEILING = 16'd2500;

	// divider sizes
	localparam int NUM_W = 36;
	localparam int DEN_W = 19;
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef struct packed {
		logic [15:0]        min_pulse;
		logic [15:0]        max_pulse;
		logic signed [10:0] map_low_angle;
		logic signed [10:0] map_high_angle;
		logic signed [9:0]  angle_offset;
		logic [7:0]         pulse_deadband;
	} sap_cfg_t;

	localparam sap_cfg_t CFG_RESET = '{
		min_pulse:      16'd1000,
		max_pulse:      16'd2000,
		map_low_angle:  11'sd0,
		map_high_angle: 11'sd180,
		angle_offset:   10'sd0,
		pulse_deadband: 8'd0
	};

endpackage

`default_nettype wire

>>> hw/rtl/sap_if.sv
`default_nettype none

// command channel
interface sap_cmd_if ();
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [16:0] angle_hundredths;
	logic [15:0]        raw_pulse;

	modport source (output valid, command, angle_hundredths, raw_pulse, input ready);
	modport sink   (input valid, command, angle_hundredths, raw_pulse, output ready);
endinterface

// result channel
interface sap_res_if ();
	logic               valid;
	logic               ready;
	logic [15:0]        compare_value;
	logic signed [17:0] limited_angle;
	logic               map_error;

	modport source (output valid, compare_value, limited_angle, map_error, input ready);
	modport sink   (input valid, compare_value, limited_angle, map_error, output ready);
endinterface

// register write channel
interface sap_cfg_if import sap_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sap_cfg_regs.sv
`default_nettype none

module sap_cfg_regs import sap_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]          wr_data,
	output sap_cfg_t                  regs
);

	sap_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MIN_PULSE:      regs_q.min_pulse      <= wr_data;
				CFG_MAX_PULSE:      regs_q.max_pulse      <= wr_data;
				CFG_MAP_LOW_ANGLE:  regs_q.map_low_angle  <= $signed(wr_data[10:0]);
				CFG_MAP_HIGH_ANGLE: regs_q.map_high_angle <= $signed(wr_data[10:0]);
				CFG_ANGLE_OFFSET:   regs_q.angle_offset   <= $signed(wr_data[9:0]);
				CFG_PULSE_DEADBAND: regs_q.pulse_deadband <= wr_data[7:0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

>>> hw/rtl/sap_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module sap_div import sap_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;
	logic [DEN_W-1:0] rem_nxt;

	assign trial     = {rem_q, acc_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = (trial >= {1'b0, dvs_q});
	// remainder stays below the divisor, so the top bit drops out
	assign rem_nxt   = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/servo_angle_to_pulse.sv
`default_nettype none

// Servo angle to pulse width converter. A transaction on cmd carries either an
// angle in hundredths of a degree or a raw pulse width; each one yields exactly
// one transaction on res holding the timer compare value, the angle clamped to
// the map range (less the offset) and a flag for a degenerate map. Angles are
// mapped linearly from the configured angle range onto the pulse range (the
// configured range limited to PULSE_FLOOR..PULSE_CEILING), rounded half away
// from zero, and then pass, like raw pulses, through a deadband filter that
// keeps the stored pulse unless the new one moves by more than the deadband.
// Items are handled one at a time: an angle item waits on the 36-step restoring
// divider that does the mapping division, while a raw item and an item with
// equal map ends skip it. A finished result sits in the output register, so the
// next item is taken while it waits; the result of that next item waits until
// it is taken. Registers must be written on cfg only while no item is in flight;
// the block itself does not enforce this. cfg is always ready and needs no
// clearing after reset.
module servo_angle_to_pulse import sap_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sap_cmd_if.sink   cmd,
	sap_res_if.source res,
	sap_cfg_if.sink   cfg
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP1  = 3'd1;
	localparam logic [2:0] ST_PREP2  = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_DIVST  = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_ROUND  = 3'd6;
	localparam logic [2:0] ST_COMMIT = 3'd7;

	logic [2:0] state_q;
	logic       res_valid_q;
	logic [15:0] last_q;   // stored pulse, also the compare value on res

	sap_cfg_t cfg_regs;

	// item payload and intermediate results
	logic signed [16:0] angle_q;
	logic [15:0]        emin_q;
	logic [15:0]        emax_q;
	logic signed [17:0] a_q;       // angle plus offset, hundredths
	logic signed [17:0] lo_q;
	logic signed [17:0] hi_q;
	logic signed [16:0] off_q;
	logic signed [18:0] dif_q;     // angle minus low end
	logic signed [18:0] den_q;     // high end minus low end
	logic signed [16:0] rng_q;     // emax minus emin
	logic signed [35:0] prod_q;
	logic [17:0]        den_abs_q;
	logic               neg_q;
	logic [15:0]        pulse_q;
	logic signed [17:0] lim_q;
	logic               err_q;
	logic signed [17:0] lim_out_q;
	logic               err_out_q;

	logic cmd_fire;
	logic commit_fire;

	// configuration registers
	sap_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (cfg_regs)
	);

	assign cfg.ready = 1'b1;

	// effective pulse range from the registers
	logic [15:0] emin_nxt;
	logic [15:0] emax_nxt;

	assign emin_nxt = (cfg_regs.min_pulse < PULSE_FLOOR)   ? PULSE_FLOOR   : cfg_regs.min_pulse;
	assign emax_nxt = (cfg_regs.max_pulse > PULSE_CEILING) ? PULSE_CEILING : cfg_regs.max_pulse;

	// first prep step: degrees to hundredths, offset added
	logic signed [16:0] off100;
	logic signed [17:0] lo100;
	logic signed [17:0] hi100;
	logic signed [17:0] a_nxt;

	assign off100 = 17'($signed(cfg_regs.angle_offset)) * 17'sd100;
	assign lo100  = 18'($signed(cfg_regs.map_low_angle)) * 18'sd100;
	assign hi100  = 18'($signed(cfg_regs.map_high_angle)) * 18'sd100;
	assign a_nxt  = 18'(angle_q) + 18'(off100);

	// second prep step: clamp for the reported angle, map operands
	logic signed [17:0] cmin;
	logic signed [17:0] cmax;
	logic signed [17:0] cl;
	logic signed [18:0] lim_wide;
	logic signed [16:0] rng_nxt;

	assign cmin     = (lo_q < hi_q) ? lo_q : hi_q;
	assign cmax     = (lo_q < hi_q) ? hi_q : lo_q;
	assign cl       = (a_q < cmin) ? cmin : ((a_q > cmax) ? cmax : a_q);
	assign lim_wide = 19'(cl) - 19'(off_q);
	assign rng_nxt  = $signed({1'b0, emax_q}) - $signed({1'b0, emin_q});

	// product of angle span and pulse span, magnitude of the angle range
	logic signed [35:0] prod;
	logic signed [18:0] den_neg;

	assign prod    = 36'(dif_q) * 36'(rng_q);
	assign den_neg = -den_q;

	// divider operands: rounding half away from zero as (2|n| + |d|) / (2|d|)
	logic [NUM_W-1:0] p2;
	logic [NUM_W-1:0] dividend;
	logic [DEN_W-1:0] divisor;
	logic             div_done;
	logic [NUM_W-1:0] quo;

	assign p2       = {prod_q[34:0], 1'b0};
	// negative product: add ~2p + 1, which is -2p
	assign dividend = (prod_q[35] ? ~p2 : p2) + NUM_W'(den_abs_q) + NUM_W'(prod_q[35]);
	assign divisor  = {den_abs_q, 1'b0};

	sap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVST),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// signed quotient plus emin, saturated to the 16-bit range
	logic signed [37:0] qs;
	logic signed [37:0] rsum;
	logic [15:0]        pulse_nxt;

	assign qs   = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	assign rsum = qs + $signed({22'd0, emin_q});

	always_comb begin
		if (rsum[37]) begin
			pulse_nxt = 16'd0;
		end else if (|rsum[36:16]) begin
			pulse_nxt = 16'hFFFF;
		end else begin
			pulse_nxt = rsum[15:0];
		end
	end

	// deadband filter and clamp to the effective range
	logic signed [16:0] pdiff;
	logic [16:0]        pdiff_abs;
	logic               take;
	logic [15:0]        clamped;
	logic [15:0]        last_nxt;

	assign pdiff     = $signed({1'b0, pulse_q}) - $signed({1'b0, last_q});
	assign pdiff_abs = pdiff[16] ? 17'(-pdiff) : 17'(pdiff);
	assign take      = !err_q && (pdiff_abs > {9'd0, cfg_regs.pulse_deadband});
	// emin is tested first, so an empty range sends anything at or above emin to emax
	assign clamped   = (pulse_q < emin_q) ? emin_q : ((pulse_q > emax_q) ? emax_q : pulse_q);
	assign last_nxt  = take ? clamped : last_q;

	assign cmd_fire    = cmd.valid && cmd.ready;
	assign commit_fire = (state_q == ST_COMMIT) && (!res_valid_q || res.ready);

	// sequencer, output valid and stored pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			// a new result may replace the one taken on this edge
			if (commit_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						state_q <= (cmd.command == CMD_RAW) ? ST_COMMIT : ST_PREP1;
					end
				end
				ST_PREP1: state_q <= ST_PREP2;
				// equal map ends skip the mapping and hold the pulse
				ST_PREP2: state_q <= (hi_q == lo_q) ? ST_COMMIT : ST_MUL;
				ST_MUL:   state_q <= ST_DIVST;
				ST_DIVST: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (commit_fire) begin
						state_q <= ST_IDLE;
						last_q  <= last_nxt;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					angle_q <= cmd.angle_hundredths;
					emin_q  <= emin_nxt;
					emax_q  <= emax_nxt;
					pulse_q <= cmd.raw_pulse;
					lim_q   <= '0;
					err_q   <= 1'b0;
				end
			end
			ST_PREP1: begin
				a_q   <= a_nxt;
				lo_q  <= lo100;
				hi_q  <= hi100;
				off_q <= off100;
			end
			ST_PREP2: begin
				lim_q <= $signed(lim_wide[17:0]);
				err_q <= (hi_q == lo_q);
				dif_q <= 19'(a_q) - 19'(lo_q);
				den_q <= 19'(hi_q) - 19'(lo_q);
				rng_q <= rng_nxt;
			end
			ST_MUL: begin
				prod_q    <= prod;
				neg_q     <= prod[35] != den_q[18];
				den_abs_q <= den_q[18] ? den_neg[17:0] : den_q[17:0];
			end
			ST_DIVST: ;
			ST_DIV:   ;
			ST_ROUND: pulse_q <= pulse_nxt;
			ST_COMMIT: begin
				if (commit_fire) begin
					lim_out_q <= lim_q;
					err_out_q <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign cmd.ready         = (state_q == ST_IDLE);
	assign res.valid         = res_valid_q;
	assign res.compare_value = last_q;
	assign res.limited_angle = lim_out_q;
	assign res.map_error     = err_out_q;

endmodule

`default_nettype wire

>>> hw/rtl/sap_checker.sv
`default_nettype none

`include "servo_angle_to_pulse_defines.svh"

module sap_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [15:0]       compare_value,
	input wire logic signed [17:0] limited_angle,
	input wire logic              map_error
);

	// a waiting result is not withdrawn
	`SAP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// a waiting result does not change
	`SAP_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(compare_value) && $stable(limited_angle) && $stable(map_error), "result changed while stalled")

	// one item in flight at a time
	`SAP_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

	// a new result only comes out of a busy cycle
	`SAP_ASSERT_SAME(a_res_from_busy, $rose(res_valid), !$past(cmd_ready), "result without work")

endmodule

bind servo_angle_to_pulse sap_checker u_sap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.compare_value (res.compare_value),
	.limited_angle (res.limited_angle),
	.map_error     (res.map_error)
);

`default_nettype wire

>>> sim/servo_angle_to_pulse_tb.sv
`timescale 1ns / 1ps

module servo_angle_to_pulse_tb import sap_pkg::*; ();

	// indexes past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	// receiver hold-off length, in cycles
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic               command;
		logic signed [16:0] angle_hundredths;
		logic [15:0]        raw_pulse;
		int unsigned        lead_gap;   // idle cycles before the offer
	} servo_cmd_t;

	typedef struct {
		logic [15:0]        compare_value;
		logic signed [17:0] limited_angle;
		logic               map_error;
	} servo_res_t;

	logic clk;
	logic arst_n;

	sap_cmd_if cmd_bus ();
	sap_res_if res_bus ();
	sap_cfg_if cfg_bus ();

	servo_angle_to_pulse u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// shadow of the block: register file and the stored pulse
	sap_cfg_t    model_cfg;
	logic [15:0] held_pulse;

	servo_cmd_t queued_commands[$];
	servo_res_t expected_pulses[$];

	// driver state, read by the stimulus process to tell when all is idle
	logic       cmd_offered;
	servo_cmd_t cmd_now;
	int         lead_count;

	// receiver controls
	int hold_requests;
	int holds_served;
	int hold_left;
	int rx_wait;
	bit rx_eager;

	int mismatch_count;
	int angle_count;
	int raw_count;
	int map_error_count;
	int settings_count;
	int last_raw_drawn;

	always #2 clk = ~clk;

	// expected outcome of one command transaction; updates the stored pulse
	function automatic servo_res_t predict_pulse(input servo_cmd_t c);
		servo_res_t r;
		longint emin, emax, lo, hi, off, a, cl, cmin, cmax;
		longint num, den, mapped, pulse, diff;
		longint unsigned mag_num, mag_den, quo;
		bit neg, has_pulse;
		emin = longint'(model_cfg.min_pulse);
		emax = longint'(model_cfg.max_pulse);
		if (emin < longint'(PULSE_FLOOR)) emin = longint'(PULSE_FLOOR);
		if (emax > longint'(PULSE_CEILING)) emax = longint'(PULSE_CEILING);
		r.limited_angle = '0;
		r.map_error = 1'b0;
		has_pulse = 1'b1;
		pulse = 0;
		if (c.command == CMD_ANGLE) begin
			lo = longint'($signed(model_cfg.map_low_angle)) * 100;
			hi = longint'($signed(model_cfg.map_high_angle)) * 100;
			off = longint'($signed(model_cfg.angle_offset)) * 100;
			a = longint'($signed(c.angle_hundredths)) + off;
			// clamp uses the smaller end as floor, whichever way the map runs
			cmin = (lo < hi) ? lo : hi;
			cmax = (lo < hi) ? hi : lo;
			cl = a;
			if (cl < cmin) cl = cmin;
			if (cl > cmax) cl = cmax;
			r.limited_angle = 18'(cl - off);
			if (hi == lo) begin
				// degenerate map: flag it and keep the stored pulse
				r.map_error = 1'b1;
				has_pulse = 1'b0;
			end else begin
				num = (a - lo) * (emax - emin);
				den = hi - lo;
				neg = (num < 0) != (den < 0);
				mag_num = (num < 0) ? -num : num;
				mag_den = (den < 0) ? -den : den;
				// round half away from zero on the magnitude
				quo = (2 * mag_num + mag_den) / (2 * mag_den);
				mapped = neg ? -longint'(quo) : longint'(quo);
				mapped = mapped + emin;
				if (mapped < 0) mapped = 0;
				if (mapped > 65535) mapped = 65535;
				pulse = mapped;
			end
		end else begin
			pulse = longint'(c.raw_pulse);
		end
		if (has_pulse) begin
			diff = pulse - longint'(held_pulse);
			if (diff < 0) diff = -diff;
			if (diff > longint'(model_cfg.pulse_deadband)) begin
				// floor tested first, so an empty range sends anything at or above emin to emax
				if (pulse < emin) pulse = emin;
				else if (pulse > emax) pulse = emax;
				held_pulse = pulse[15:0];
			end
		end
		r.compare_value = held_pulse;
		return r;
	endfunction

	// random command shaped around the current map and deadband
	function automatic servo_cmd_t draw_command(input bit eager);
		servo_cmd_t c;
		int lo_deg, hi_deg, off_deg, pick, val, db;
		lo_deg = $signed(model_cfg.map_low_angle);
		hi_deg = $signed(model_cfg.map_high_angle);
		off_deg = $signed(model_cfg.angle_offset);
		db = model_cfg.pulse_deadband;
		c.lead_gap = eager ? 0 : $urandom_range(0, 8);
		c.command = ($urandom_range(0, 9) < 3) ? CMD_RAW : CMD_ANGLE;
		c.angle_hundredths = 17'($urandom);
		c.raw_pulse = 16'($urandom);
		pick = $urandom_range(0, 19);
		if (c.command == CMD_ANGLE) begin
			if (pick < 12) begin
				// across the map range plus a margin either side
				val = ((lo_deg < hi_deg) ? lo_deg : hi_deg) * 100 - 500;
				val = val + int'($urandom_range(0, (hi_deg - lo_deg) * ((hi_deg > lo_deg) ? 100 : -100) + 1000));
				c.angle_hundredths = 17'(val - off_deg * 100);
			end else if (pick < 15) begin
				// a hair either side of one map end
				val = ((pick == 12) ? lo_deg : hi_deg) * 100 - off_deg * 100;
				c.angle_hundredths = 17'(val + int'($urandom_range(0, 4)) - 2);
			end else if (pick < 17) begin
				case ($urandom_range(0, 4))
					0: c.angle_hundredths = 17'sh0FFFF;
					1: c.angle_hundredths = 17'sh10000;
					2: c.angle_hundredths = 17'sd36000;
					3: c.angle_hundredths = -17'sd36000;
					default: c.angle_hundredths = '0;
				endcase
			end
		end else begin
			if (pick < 7) begin
				// close to the previous raw pulse, straddling the deadband
				val = last_raw_drawn + int'($urandom_range(0, 2 * db + 4)) - (db + 2);
				c.raw_pulse = 16'(val);
			end else if (pick < 14) begin
				c.raw_pulse = 16'($urandom_range(0, 3000));
			end else if (pick < 17) begin
				case ($urandom_range(0, 3))
					0: c.raw_pulse = 16'h0000;
					1: c.raw_pulse = 16'hFFFF;
					2: c.raw_pulse = model_cfg.min_pulse;
					default: c.raw_pulse = model_cfg.max_pulse;
				endcase
			end
			last_raw_drawn = c.raw_pulse;
		end
		return c;
	endfunction

	task automatic push_cmd(input logic kind, input int angle, input int raw);
		servo_cmd_t c;
		c.command = kind;
		c.angle_hundredths = 17'(angle);
		c.raw_pulse = 16'(raw);
		c.lead_gap = $urandom_range(0, 8);
		queued_commands.push_back(c);
	endtask

	// sender pause: nothing queued, nothing on offer, every result back
	task automatic wait_idle();
		while (queued_commands.size() > 0 || cmd_offered || expected_pulses.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			CFG_MIN_PULSE:      model_cfg.min_pulse = val;
			CFG_MAX_PULSE:      model_cfg.max_pulse = val;
			CFG_MAP_LOW_ANGLE:  model_cfg.map_low_angle = val[10:0];
			CFG_MAP_HIGH_ANGLE: model_cfg.map_high_angle = val[10:0];
			CFG_ANGLE_OFFSET:   model_cfg.angle_offset = val[9:0];
			CFG_PULSE_DEADBAND: model_cfg.pulse_deadband = val[7:0];
			default: ;
		endcase
	endtask

	// full register set, written only once the block has gone quiet
	task automatic apply_settings(input int min_p, input int max_p, input int lo_deg,
			input int hi_deg, input int off_deg, input int db);
		wait_idle();
		write_register(CFG_MIN_PULSE, 16'(min_p));
		write_register(CFG_MAX_PULSE, 16'(max_p));
		write_register(CFG_MAP_LOW_ANGLE, 16'(lo_deg));
		write_register(CFG_MAP_HIGH_ANGLE, 16'(hi_deg));
		write_register(CFG_ANGLE_OFFSET, 16'(off_deg));
		write_register(CFG_PULSE_DEADBAND, 16'(db));
		settings_count++;
	endtask

	// random traffic, optionally with a mid-run sender pause or a long receiver hold
	task automatic run_phase(input int count, input bit with_pause, input bit with_hold);
		bit burst;
		burst = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				if (with_pause) wait_idle();
				if (with_hold) begin
					// keep offering back to back while the receiver sits out
					hold_requests++;
					for (int k = 0; k < 20; k++) queued_commands.push_back(draw_command(1'b1));
				end
			end
			if ($urandom_range(0, 24) == 0) burst = !burst;
			queued_commands.push_back(draw_command(burst));
		end
	endtask

	// command driver: takes transactions from the queue with the drawn lead gap
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_offered = 1'b0;
			lead_count = 0;
		end else begin
			if (cmd_offered && cmd_bus.ready) begin
				expected_pulses.push_back(predict_pulse(cmd_now));
				if (cmd_now.command == CMD_RAW) raw_count++;
				else angle_count++;
				cmd_offered = 1'b0;
			end
			if (!cmd_offered && queued_commands.size() > 0) begin
				if (lead_count < queued_commands[0].lead_gap) begin
					lead_count++;
				end else begin
					cmd_now = queued_commands.pop_front();
					lead_count = 0;
					cmd_offered = 1'b1;
					cmd_bus.command          <= cmd_now.command;
					cmd_bus.angle_hundredths <= cmd_now.angle_hundredths;
					cmd_bus.raw_pulse        <= cmd_now.raw_pulse;
				end
			end
			// single update of valid per edge, so back-to-back offers stay high
			cmd_bus.valid <= cmd_offered;
		end
	end

	// result monitor: checks each transaction against the oldest prediction
	always @(posedge clk) begin
		servo_res_t want;
		logic       ready_next;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (res_bus.map_error) map_error_count++;
				if (expected_pulses.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_pulses.pop_front();
					if (res_bus.compare_value !== want.compare_value) begin
						$error("compare_value: expected %0d, got %0d",
							want.compare_value, res_bus.compare_value);
						mismatch_count++;
					end
					if (res_bus.limited_angle !== want.limited_angle) begin
						$error("limited_angle: expected %0d, got %0d",
							want.limited_angle, res_bus.limited_angle);
						mismatch_count++;
					end
					if (res_bus.map_error !== want.map_error) begin
						$error("map_error: expected %0d, got %0d",
							want.map_error, res_bus.map_error);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 24) == 0) rx_eager = !rx_eager;
				rx_wait = rx_eager ? 0 : $urandom_range(0, 8);
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			res_bus.ready <= ready_next;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_ANGLE;
		cmd_bus.angle_hundredths = '0;
		cmd_bus.raw_pulse = '0;
		res_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_MIN_PULSE;
		cfg_bus.data = '0;
		cmd_offered = 1'b0;
		model_cfg = CFG_RESET;
		held_pulse = '0;
		hold_requests = 0;
		holds_served = 0;
		rx_eager = 1'b0;
		mismatch_count = 0;
		angle_count = 0;
		raw_count = 0;
		map_error_count = 0;
		settings_count = 1;
		last_raw_drawn = 1500;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed set under the reset registers (0..180 deg onto 1000..2000)
		push_cmd(CMD_RAW, 0, 0);            // equal to the unclamped stored zero
		push_cmd(CMD_RAW, 0, 65535);        // clamps to emax
		push_cmd(CMD_RAW, 0, 0);            // clamps to emin
		push_cmd(CMD_ANGLE, 0, 0);
		push_cmd(CMD_ANGLE, 18000, 0);
		push_cmd(CMD_ANGLE, 9000, 0);
		push_cmd(CMD_ANGLE, 9, 65535);      // exactly half a unit, rounds up
		push_cmd(CMD_ANGLE, 4, 0);
		push_cmd(CMD_ANGLE, -9, 0);         // half a unit below, rounds away then clamps
		push_cmd(CMD_ANGLE, 36000, 0);
		push_cmd(CMD_ANGLE, -36000, 0);
		push_cmd(CMD_ANGLE, 65535, 0);      // widest positive pattern
		push_cmd(CMD_ANGLE, -65536, 0);     // widest negative pattern
		push_cmd(CMD_RAW, 0, 1500);
		push_cmd(CMD_RAW, 0, 1500);         // same pulse, zero deadband
		push_cmd(CMD_RAW, 0, 1501);
		push_cmd(CMD_RAW, 0, 43690);
		push_cmd(CMD_RAW, 0, 21845);
		wait_idle();

		// full span and floor/ceiling limits
		apply_settings(0, 65535, -720, 720, 0, 0);
		run_phase(170, 1'b1, 1'b0);
		// reversed map with offset and a small deadband; long receiver hold
		apply_settings(1000, 2000, 180, 0, 90, 10);
		run_phase(170, 1'b0, 1'b1);
		// equal map ends
		apply_settings(1500, 1500, 45, 45, -360, 0);
		run_phase(120, 1'b0, 1'b0);
		// empty pulse range, widest deadband
		apply_settings(3000, 1000, -90, 90, 360, 255);
		run_phase(150, 1'b1, 1'b0);
		apply_settings(65535, 0, 720, -720, -45, 3);
		run_phase(150, 1'b0, 1'b1);
		// register patterns past the documented ranges, plus unused indexes
		apply_settings(500, 2500, -1024, 1023, -512, 1);
		write_register(CFG_SPARE_A, 16'($urandom));
		write_register(CFG_SPARE_B, 16'($urandom));
		run_phase(150, 1'b0, 1'b0);
		repeat (4) begin
			int lo_deg, hi_deg;
			lo_deg = int'($urandom_range(0, 1440)) - 720;
			hi_deg = ($urandom_range(0, 3) == 0) ? lo_deg : int'($urandom_range(0, 1440)) - 720;
			apply_settings(($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 3000)) : int'($urandom),
				($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 3000)) : int'($urandom),
				lo_deg, hi_deg, int'($urandom_range(0, 720)) - 360, $urandom_range(0, 255));
			run_phase(150, 1'b0, 1'b0);
		end
		apply_settings(800, 2200, -180, 180, 511, 0);
		run_phase(150, 1'b1, 1'b0);

		// drain, then allow for the slowest item to settle
		while (queued_commands.size() > 0 || cmd_offered || expected_pulses.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("run covered %0d angle and %0d raw commands across %0d register settings",
			angle_count, raw_count, settings_count);
		$display("%0d results carried the degenerate-map flag", map_error_count);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sap_pkg.sv
hw/rtl/sap_if.sv
hw/rtl/sap_cfg_regs.sv
hw/rtl/sap_div.sv
hw/rtl/servo_angle_to_pulse.sv
hw/rtl/sap_checker.sv
sim/servo_angle_to_pulse_tb.sv
